// File: sv/assert_macros.svh
// Assertion helpers for the RTL; barometric_pressure_compensation.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked on every rising edge outside reset.
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bpc assertion failed");
// Checked on every rising edge, reset included.
`define BPC_ASSERT_ANY(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("bpc assertion failed");
`else
`define BPC_ASSERT(lbl, clk, rst_n, prop)
`define BPC_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

// File: sv/bpc_pkg.sv
package bpc_pkg;

	localparam int RAW_W = 19;

	// Configuration register indexes.
	localparam logic [2:0] REG_AC1_AC2 = 3'd0;
	localparam logic [2:0] REG_AC3_AC4 = 3'd1;
	localparam logic [2:0] REG_AC5_AC6 = 3'd2;
	localparam logic [2:0] REG_B1_B2   = 3'd3;
	localparam logic [2:0] REG_MC_MD   = 3'd4;
	localparam logic [2:0] REG_OSS     = 3'd5;

	localparam logic [1:0]  OSS_RESET   = 2'd3;
	localparam logic [31:0] K_B6_OFS    = 32'd4000;
	localparam logic [31:0] K_C3038     = 32'd3038;
	localparam logic [31:0] K_CM7357    = 32'hFFFF_E343;
	localparam logic [31:0] K_C3791     = 32'd3791;
	localparam logic [31:0] K_P_SCALE   = 32'd50000;
	localparam logic [31:0] K_X3_OFS    = 32'd32768;
	localparam logic [5:0]  DIV_STEPS   = 6'd32;

	typedef struct packed {
		logic start;
		logic is_signed;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
		return 32'($signed(v) >>> s);
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// File: sv/bpc_div.sv
module bpc_div import bpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  div_req_t    req,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output div_stat_t   stat,
	output logic [31:0] quo
);

	typedef enum logic [3:0] {
		D_IDLE = 4'b0001,
		D_RUN  = 4'b0010,
		D_FIX  = 4'b0100,
		D_DONE = 4'b1000
	} dstate_t;

	dstate_t     state_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;

	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        fits;
	logic        num_neg;
	logic        den_neg;

	assign rem_sh  = {rem_q, quo_q[31]};
	assign diff    = rem_sh - {1'b0, den_q};
	assign fits    = !diff[32];
	assign num_neg = req.is_signed & num[31];
	assign den_neg = req.is_signed & den[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_RUN;
						cnt_q   <= DIV_STEPS;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= D_FIX;
					end
				end
				D_FIX:   state_q <= D_DONE;
				D_DONE:  state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Restoring division on magnitudes, one quotient bit per cycle; the sign is
	// applied in the D_FIX state.
	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (req.start) begin
					quo_q <= num_neg ? (~num + 32'd1) : num;
					den_q <= den_neg ? (~den + 32'd1) : den;
					neg_q <= num_neg ^ den_neg;
					rem_q <= '0;
				end
			end
			D_RUN: begin
				rem_q <= fits ? diff[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[30:0], fits};
			end
			D_FIX: begin
				if (neg_q) begin
					quo_q <= ~quo_q + 32'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (state_q != D_IDLE);
	assign stat.done = (state_q == D_DONE);
	assign quo       = quo_q;

endmodule

// File: sv/barometric_pressure_compensation.sv
// The 32-step serial divider and the single shared 32x32 multiplier carry the
// arithmetic; a zero divisor skips the division and flags divide_error.
// One transaction is in flight at a time: in_ready is low while busy, until the
// result has been handed to the output register.
// Reset (arst_n low, asynchronous): calibration registers and temp_term go to zero,
// oversampling to 3, the sequencer to idle and out_valid low.
`include "assert_macros.svh"
module barometric_pressure_compensation import bpc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             mode,
	input  logic [RAW_W-1:0] raw_value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      result_value,
	output logic             result_is_pressure,
	output logic             divide_error
);

	typedef enum logic [23:0] {
		S_IDLE   = 24'h000001,
		S_T_SUB  = 24'h000002,
		S_T_MUL  = 24'h000004,
		S_T_X1   = 24'h000008,
		S_T_DEN  = 24'h000010,
		S_T_WAIT = 24'h000020,
		S_P_B6   = 24'h000040,
		S_P_SQ   = 24'h000080,
		S_P_AC2  = 24'h000100,
		S_P_B2   = 24'h000200,
		S_P_AC3  = 24'h000400,
		S_P_B1   = 24'h000800,
		S_P_X3   = 24'h001000,
		S_P_K    = 24'h002000,
		S_P_B7   = 24'h004000,
		S_P_B4   = 24'h008000,
		S_P_DIV  = 24'h010000,
		S_P_WAIT = 24'h020000,
		S_P_T    = 24'h040000,
		S_P_C1   = 24'h080000,
		S_P_C2   = 24'h100000,
		S_P_C3   = 24'h200000,
		S_P_C4   = 24'h400000,
		S_DONE   = 24'h800000
	} state_t;

	state_t state_q;

	logic [31:0] cal_ac1_ac2_q, cal_ac3_ac4_q, cal_ac5_ac6_q, cal_b1_b2_q, cal_mc_md_q;
	logic [1:0]  oss_q;
	logic [31:0] temp_q;

	logic             mode_q;
	logic [RAW_W-1:0] raw_q;
	logic [31:0]      prod_q, acc_q, x_q, b6_q, sq_q, b3_q, b7_q, b4_q, p_q, res_q;
	logic             err_q;
	logic             out_valid_q;
	logic [31:0]      out_value_q;
	logic             out_pres_q, out_err_q;

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	logic [31:0] raw_ext, mul_a, mul_b, b3_sum, b3_shl, p_sh8, b5;
	logic        out_free;

	div_req_t    div_req;
	div_stat_t   div_stat;
	logic [31:0] div_num, div_den, div_quo;

	assign ac1 = sx16(cal_ac1_ac2_q[31:16]);
	assign ac2 = sx16(cal_ac1_ac2_q[15:0]);
	assign ac3 = sx16(cal_ac3_ac4_q[31:16]);
	assign ac4 = {16'd0, cal_ac3_ac4_q[15:0]};
	assign ac5 = {16'd0, cal_ac5_ac6_q[31:16]};
	assign ac6 = {16'd0, cal_ac5_ac6_q[15:0]};
	assign b1  = sx16(cal_b1_b2_q[31:16]);
	assign b2  = sx16(cal_b1_b2_q[15:0]);
	assign mc  = sx16(cal_mc_md_q[31:16]);
	assign md  = sx16(cal_mc_md_q[15:0]);

	assign raw_ext  = {{(32-RAW_W){1'b0}}, raw_q};
	assign b3_sum   = (ac1 << 2) + acc_q;
	assign b3_shl   = b3_sum << oss_q;
	assign p_sh8    = asr(p_q, 5'd8);
	assign b5       = x_q + div_quo;
	assign out_free = !out_valid_q || out_ready;

	assign in_ready           = (state_q == S_IDLE);
	assign out_valid          = out_valid_q;
	assign result_value       = out_value_q;
	assign result_is_pressure = out_pres_q;
	assign divide_error       = out_err_q;

	// Operand select for the shared multiplier; only the low 32 bits of the product
	// are kept, which is the same for signed and unsigned operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T_MUL: begin
				mul_a = acc_q;
				mul_b = ac5;
			end
			S_P_SQ: begin
				mul_a = b6_q;
				mul_b = b6_q;
			end
			S_P_AC2: begin
				mul_a = ac2;
				mul_b = b6_q;
			end
			S_P_B2: begin
				mul_a = b2;
				mul_b = sq_q;
			end
			S_P_AC3: begin
				mul_a = ac3;
				mul_b = b6_q;
			end
			S_P_B1: begin
				mul_a = b1;
				mul_b = sq_q;
			end
			S_P_K: begin
				mul_a = acc_q;
				mul_b = K_P_SCALE >> oss_q;
			end
			S_P_B7: begin
				mul_a = ac4;
				mul_b = x_q;
			end
			S_P_T: begin
				mul_a = p_sh8;
				mul_b = p_sh8;
			end
			S_P_C1: begin
				mul_a = p_q;
				mul_b = K_CM7357;
			end
			S_P_C2: begin
				mul_a = x_q;
				mul_b = K_C3038;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		div_req.start     = ((state_q == S_T_DEN) && (acc_q != 32'd0)) ||
		                    ((state_q == S_P_DIV) && (b4_q != 32'd0));
		div_req.is_signed = (state_q == S_T_DEN);
		if (state_q == S_T_DEN) begin
			div_num = mc << 11;
			div_den = acc_q;
		end else begin
			div_num = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
			div_den = b4_q;
		end
	end

	bpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_ac1_ac2_q <= '0;
			cal_ac3_ac4_q <= '0;
			cal_ac5_ac6_q <= '0;
			cal_b1_b2_q   <= '0;
			cal_mc_md_q   <= '0;
			oss_q         <= OSS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AC1_AC2: cal_ac1_ac2_q <= cfg_data;
				REG_AC3_AC4: cal_ac3_ac4_q <= cfg_data;
				REG_AC5_AC6: cal_ac5_ac6_q <= cfg_data;
				REG_B1_B2:   cal_b1_b2_q   <= cfg_data;
				REG_MC_MD:   cal_mc_md_q   <= cfg_data;
				REG_OSS:     oss_q         <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, stored temperature term and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			temp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= mode ? S_P_B6 : S_T_SUB;
					end
				end
				S_T_SUB: state_q <= S_T_MUL;
				S_T_MUL: state_q <= S_T_X1;
				S_T_X1:  state_q <= S_T_DEN;
				S_T_DEN: state_q <= (acc_q == 32'd0) ? S_DONE : S_T_WAIT;
				S_T_WAIT: begin
					if (div_stat.done) begin
						temp_q  <= b5;
						state_q <= S_DONE;
					end
				end
				S_P_B6:  state_q <= S_P_SQ;
				S_P_SQ:  state_q <= S_P_AC2;
				S_P_AC2: state_q <= S_P_B2;
				S_P_B2:  state_q <= S_P_AC3;
				S_P_AC3: state_q <= S_P_B1;
				S_P_B1:  state_q <= S_P_X3;
				S_P_X3:  state_q <= S_P_K;
				S_P_K:   state_q <= S_P_B7;
				S_P_B7:  state_q <= S_P_B4;
				S_P_B4:  state_q <= S_P_DIV;
				S_P_DIV: state_q <= (b4_q == 32'd0) ? S_DONE : S_P_WAIT;
				S_P_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_P_T;
					end
				end
				S_P_T:   state_q <= S_P_C1;
				S_P_C1:  state_q <= S_P_C2;
				S_P_C2:  state_q <= S_P_C3;
				S_P_C3:  state_q <= S_P_C4;
				S_P_C4:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (state_q == S_DONE && out_free) begin
			out_value_q <= res_q;
			out_pres_q  <= mode_q;
			out_err_q   <= err_q;
		end
		unique case (state_q)
			S_IDLE: begin
				mode_q <= mode;
				raw_q  <= raw_value;
				err_q  <= 1'b0;
			end
			S_T_SUB: acc_q <= raw_ext - ac6;
			S_T_X1: begin
				x_q   <= asr(prod_q, 5'd15);
				acc_q <= asr(prod_q, 5'd15) + md;
			end
			S_T_DEN: begin
				if (acc_q == 32'd0) begin
					res_q <= '0;
					err_q <= 1'b1;
				end
			end
			S_T_WAIT: res_q <= asr(b5 + 32'd8, 5'd4);
			S_P_B6:   b6_q  <= temp_q - K_B6_OFS;
			S_P_AC2:  sq_q  <= asr(prod_q, 5'd12);
			S_P_B2:   acc_q <= asr(prod_q, 5'd11);
			S_P_AC3:  acc_q <= acc_q + asr(prod_q, 5'd11);
			S_P_B1: begin
				b3_q <= asr(b3_shl + 32'd2, 5'd2);
				x_q  <= asr(prod_q, 5'd13);
			end
			S_P_X3: begin
				x_q   <= asr(x_q + asr(prod_q, 5'd16) + 32'd2, 5'd2);
				acc_q <= raw_ext - b3_q;
			end
			S_P_K:  x_q  <= x_q + K_X3_OFS;
			S_P_B7: b7_q <= prod_q;
			S_P_B4: b4_q <= prod_q >> 15;
			S_P_DIV: begin
				if (b4_q == 32'd0) begin
					res_q <= '0;
					err_q <= 1'b1;
				end
			end
			S_P_WAIT: p_q   <= b7_q[31] ? {div_quo[30:0], 1'b0} : div_quo;
			S_P_C1:   x_q   <= prod_q;
			S_P_C2:   acc_q <= asr(prod_q, 5'd16);
			S_P_C3:   acc_q <= acc_q + asr(prod_q, 5'd16) + K_C3791;
			S_P_C4:   res_q <= p_q + asr(acc_q, 5'd4);
			default: begin
			end
		endcase
	end

	// An accepted transaction always takes the block out of the ready state.
	`BPC_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	// The divider only runs while the sequencer waits for it.
	`BPC_ASSERT(a_div_in_wait, clk, arst_n, div_stat.busy |-> (state_q == S_T_WAIT || state_q == S_P_WAIT))
	// The stored temperature term changes only when a temperature division finishes.
	`BPC_ASSERT(a_temp_update, clk, arst_n, !$stable(temp_q) |-> $past(state_q == S_T_WAIT && div_stat.done))
	// The divider is never active while a new transaction can be taken.
	`BPC_ASSERT(a_idle_div_idle, clk, arst_n, !(in_ready && div_stat.busy))

endmodule

// File: tb/sv/barometric_pressure_compensation_test.sv
module barometric_pressure_compensation_test;
	import bpc_pkg::*;

	localparam logic MODE_TEMP     = 1'b0;
	localparam logic MODE_PRESSURE = 1'b1;

	localparam int HOLD_CYCLES       = 300;
	localparam int SETTLE_CYCLES     = 60;
	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int RANDOM_SETTINGS   = 12;
	localparam int ITEMS_PER_SETTING = 100;

	// Typical factory calibration, packed the way the registers hold it.
	localparam logic [31:0] TYP_AC1_AC2 = 32'h0198_FFB8;
	localparam logic [31:0] TYP_AC3_AC4 = 32'hC7D1_7FE5;
	localparam logic [31:0] TYP_AC5_AC6 = 32'h7FF5_5A71;
	localparam logic [31:0] TYP_B1_B2   = 32'h182E_0004;
	localparam logic [31:0] TYP_MC_MD   = 32'hDDF9_0B34;

	typedef struct packed {
		logic [31:0] value;
		logic        is_pressure;
		logic        div_err;
	} reading_t;

	class pressure_scoreboard;
		logic [31:0] cal [6];
		logic [31:0] b5_held;
		reading_t    pending_readings [$];
		int          failures;
		int          n_temp;
		int          n_press;
		int          n_div_err;

		function new();
			for (int i = 0; i < 6; i++)
				cal[i] = '0;
			cal[REG_OSS] = {30'd0, OSS_RESET};
			b5_held = '0;
			failures = 0;
			n_temp = 0;
			n_press = 0;
			n_div_err = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			if (idx == REG_OSS)
				cal[idx] = {30'd0, data[1:0]};
			else
				cal[idx] = data;
		endfunction

		function logic [31:0] sra32(logic [31:0] v, int s);
			return 32'($signed(v) >>> s);
		endfunction

		// Integer compensation; every intermediate wraps at 32 bits.
		function reading_t compensate(logic m, logic [RAW_W-1:0] raw);
			logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
			logic [31:0] rw, x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
			logic signed [31:0] num_s, den_s;
			longint quo;
			logic [1:0] oss;
			reading_t res;
			ac1 = {{16{cal[0][31]}}, cal[0][31:16]};
			ac2 = {{16{cal[0][15]}}, cal[0][15:0]};
			ac3 = {{16{cal[1][31]}}, cal[1][31:16]};
			ac4 = {16'd0, cal[1][15:0]};
			ac5 = {16'd0, cal[2][31:16]};
			ac6 = {16'd0, cal[2][15:0]};
			b1 = {{16{cal[3][31]}}, cal[3][31:16]};
			b2 = {{16{cal[3][15]}}, cal[3][15:0]};
			mc = {{16{cal[4][31]}}, cal[4][31:16]};
			md = {{16{cal[4][15]}}, cal[4][15:0]};
			oss = cal[REG_OSS][1:0];
			rw = {{(32 - RAW_W){1'b0}}, raw};
			res.value = '0;
			res.is_pressure = m;
			res.div_err = 1'b0;
			if (m == MODE_TEMP) begin
				n_temp++;
				x1 = sra32((rw - ac6) * ac5, 15);
				den = x1 + md;
				if (den == '0) begin
					res.div_err = 1'b1;
				end else begin
					num_s = mc << 11;
					den_s = den;
					quo = longint'(num_s) / longint'(den_s);
					b5 = x1 + quo[31:0];
					b5_held = b5;
					res.value = sra32(b5 + 32'd8, 4);
				end
			end else begin
				n_press++;
				b6 = b5_held - 32'd4000;
				sq = sra32(b6 * b6, 12);
				x1 = sra32(b2 * sq, 11);
				x2 = sra32(ac2 * b6, 11);
				x3 = x1 + x2;
				b3 = sra32(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
				x1 = sra32(ac3 * b6, 13);
				x2 = sra32(b1 * sq, 16);
				x3 = sra32(x1 + x2 + 32'd2, 2);
				b4 = (ac4 * (x3 + 32'd32768)) >> 15;
				b7 = (rw - b3) * (32'd50000 >> oss);
				if (b4 == '0) begin
					res.div_err = 1'b1;
				end else begin
					// Keep the doubling inside 32 bits for large B7.
					if (b7 < 32'h8000_0000)
						p = (b7 << 1) / b4;
					else
						p = (b7 / b4) << 1;
					x1 = sra32(p, 8) * sra32(p, 8);
					x1 = sra32(x1 * 32'd3038, 16);
					x2 = sra32(-32'd7357 * p, 16);
					p = p + sra32(x1 + x2 + 32'd3791, 4);
					res.value = p;
				end
			end
			if (res.div_err)
				n_div_err++;
			return res;
		endfunction

		function void note_input(logic m, logic [RAW_W-1:0] raw);
			pending_readings.push_back(compensate(m, raw));
		endfunction

		function void check_result(logic [31:0] v, logic is_p, logic err);
			reading_t want;
			if (pending_readings.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: value=%0d pressure=%0b error=%0b",
						$signed(v), is_p, err);
				return;
			end
			want = pending_readings.pop_front();
			if (want.value !== v || want.is_pressure !== is_p || want.div_err !== err) begin
				failures++;
				if (failures <= 10)
					$display("mismatch: expected value=%0d pressure=%0b error=%0b, got value=%0d pressure=%0b error=%0b",
						$signed(want.value), want.is_pressure, want.div_err,
						$signed(v), is_p, err);
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [2:0]       cfg_index = '0;
	logic [31:0]      cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             mode = 1'b0;
	logic [RAW_W-1:0] raw_value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [31:0]      result_value;
	logic             result_is_pressure;
	logic             divide_error;

	logic no_idle = 1'b0;
	int   hold_count = 0;
	int   settings = 0;
	pressure_scoreboard sb;

	barometric_pressure_compensation u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.raw_value         (raw_value),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_value      (result_value),
		.result_is_pressure(result_is_pressure),
		.divide_error      (divide_error)
	);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw(logic m, logic [1:0] oss);
		if ($urandom_range(0, 9) == 0)
			return RAW_W'($urandom);
		if (m == MODE_TEMP)
			return RAW_W'($urandom_range(15000, 45000));
		return RAW_W'($urandom_range(15000, 40000) << oss);
	endfunction

	function automatic logic [31:0] vary_cal(logic [31:0] typical);
		logic [15:0] hi, lo;
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		hi = typical[31:16] + 16'($urandom_range(0, 1023)) - 16'd512;
		lo = typical[15:0] + 16'($urandom_range(0, 1023)) - 16'd512;
		return {hi, lo};
	endfunction

	task automatic send_item(input logic m, input logic [RAW_W-1:0] r);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		raw_value <= r;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(m, r);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold off new input until every outstanding result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] w0, w1, w2, w3, w4,
			input logic [1:0] oss);
		drain();
		write_reg(REG_AC1_AC2, w0);
		write_reg(REG_AC3_AC4, w1);
		write_reg(REG_AC5_AC6, w2);
		write_reg(REG_B1_B2, w3);
		write_reg(REG_MC_MD, w4);
		write_reg(REG_OSS, {30'd0, oss});
		settings++;
	endtask

	// Result side: checks every transaction and stalls at random.
	initial begin
		int stall_left;
		int holds_served;
		int r;
		stall_left = 0;
		holds_served = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(result_value, result_is_pressure, divide_error);
			if (hold_count != holds_served) begin
				holds_served = hold_count;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (no_idle) begin
				out_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_ready <= 1'b1;
				end else begin
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
					out_ready <= 1'b0;
				end
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("barometric_pressure_compensation_test failed");
		$finish;
	end

	initial begin
		logic m;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset calibration is all zero, so both divisors are zero; pressure comes
		// before any temperature.
		send_item(MODE_PRESSURE, '0);
		send_item(MODE_TEMP, '1);

		apply_setting(TYP_AC1_AC2, TYP_AC3_AC4, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 2'd0);
		send_item(MODE_TEMP, 19'd27898);
		send_item(MODE_PRESSURE, 19'd23843);
		send_item(MODE_TEMP, '0);
		send_item(MODE_PRESSURE, '0);
		send_item(MODE_TEMP, '1);
		send_item(MODE_PRESSURE, '1);

		apply_setting(TYP_AC1_AC2, TYP_AC3_AC4, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 2'd3);
		send_item(MODE_TEMP, 19'h2AAAA);
		send_item(MODE_PRESSURE, 19'h55555);
		send_item(MODE_PRESSURE, '1);

		// With AC5 at 32768 the first term is raw - AC6, so raw 900 cancels MD.
		// The pressure after it must still use the earlier temperature term.
		apply_setting(TYP_AC1_AC2, TYP_AC3_AC4, 32'h8000_03E8, TYP_B1_B2, 32'hDDF9_0064, 2'd1);
		send_item(MODE_TEMP, 19'd1200);
		send_item(MODE_TEMP, 19'd900);
		send_item(MODE_PRESSURE, 19'd47000);

		apply_setting(TYP_AC1_AC2, 32'hC7D1_0000, TYP_AC5_AC6, TYP_B1_B2, TYP_MC_MD, 2'd2);
		send_item(MODE_PRESSURE, 19'd94000);

		apply_setting('1, '1, '1, '1, '1, 2'd3);
		send_item(MODE_TEMP, '0);
		send_item(MODE_TEMP, '1);
		send_item(MODE_PRESSURE, '1);

		apply_setting(32'h8000_7FFF, 32'h8000_FFFF, 32'hFFFF_0000, 32'h7FFF_8000,
			32'h8000_7FFF, 2'd0);
		send_item(MODE_TEMP, '1);
		send_item(MODE_PRESSURE, '0);
		send_item(MODE_PRESSURE, '1);

		for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
			apply_setting(vary_cal(TYP_AC1_AC2), vary_cal(TYP_AC3_AC4), vary_cal(TYP_AC5_AC6),
				vary_cal(TYP_B1_B2), vary_cal(TYP_MC_MD), 2'(ph % 4));
			no_idle = (ph % 4 == 2);
			send_item(MODE_TEMP, pick_raw(MODE_TEMP, 2'(ph % 4)));
			for (int i = 1; i < ITEMS_PER_SETTING; i++) begin
				// One long output stall while input keeps coming, so the block backs up.
				if (ph == 5 && i == 20)
					hold_count++;
				m = ($urandom_range(0, 3) == 0) ? MODE_TEMP : MODE_PRESSURE;
				send_item(m, pick_raw(m, 2'(ph % 4)));
			end
			no_idle = 1'b0;
		end

		drain();
		$display("Covered %0d temperature and %0d pressure transactions under %0d calibration settings.",
			sb.n_temp, sb.n_press, settings + 1);
		$display("%0d transactions hit a zero divisor; %0d result failures.",
			sb.n_div_err, sb.failures);
		if (sb.failures == 0 && sb.pending_readings.size() == 0) begin
			$display("barometric_pressure_compensation_test passed");
		end else begin
			$display("barometric_pressure_compensation_test failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_div.sv
sv/barometric_pressure_compensation.sv
tb/sv/barometric_pressure_compensation_test.sv
